### rtl/rsm_pkg.sv
package rsm_pkg;

    // default row length and register reset
    localparam int ROW_LEN_DEF = 16;
    localparam logic [15:0] EPS_RESET = 16'd1;

    // log2(e) in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // quotient bits produced by the divider
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               row_end;
    } in_word_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        final_of_row;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic first;
        logic exp_rd;
        logic exp_mul;
        logic exp_int;
        logic exp_wr;
        logic div_rd;
        logic div_init;
        logic div_step;
        logic out_load;
        logic out_last;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_full;
    } sts_t;

    // round(65536 * 2^(-j/16))
    function automatic logic [16:0] pow2_frac(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### rtl/row_softmax_top.sv
// Row softmax: logits arrive one word per handshake (signed Q8.8) and are
// stored until row_end or until ROW_LEN words close the row. The block then
// finds exp(x - max) for each element (Q1.16, shift plus interpolated table),
// sums them and returns one Q0.16 probability word per element, in arrival
// order, with final_of_row on the last. Input is taken one word per cycle
// while loading; after the row closes no input is taken until the last
// probability is loaded into the output register. The block first computes
// the exponential of every element (RAM read, two registered multiplies,
// write), then divides each one (RAM read, setup, restoring divider, output
// load). epsilon (cfg_we/cfg_data) resets to 1 and is to be written while
// idle; the user must ensure this, as the block does not enforce it.
module row_softmax_top #(
    parameter int ROW_LEN = rsm_pkg::ROW_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsm_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import rsm_pkg::*;

    cmd_t                       cmd;
    sts_t                       sts;
    logic [$clog2(ROW_LEN)-1:0] addr;

    rsm_ctrl #(.ROW_LEN(ROW_LEN)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .row_end  (in_data.row_end),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    rsm_dp #(.ROW_LEN(ROW_LEN)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .addr      (addr),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // never overwrite a waiting result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_full)
        else $error("result loaded over a waiting word");

    // a loaded result shows up next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

    // input taken only outside the compute phases
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exp_wr || cmd.div_step || cmd.out_load) |-> !in_ready)
        else $error("input ready while computing");

endmodule

### rtl/rsm_ram.sv
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rsm_ctrl.sv
module rsm_ctrl #(
    parameter int ROW_LEN = rsm_pkg::ROW_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       row_end,
    output logic                       in_ready,
    input  rsm_pkg::sts_t              sts,
    output rsm_pkg::cmd_t              cmd,
    output logic [$clog2(ROW_LEN)-1:0] addr
);
    import rsm_pkg::*;

    localparam int IDX_W = $clog2(ROW_LEN);
    localparam int CNT_W = $clog2(ROW_LEN + 1);

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_ERD   = 9'b000000010,
        S_EMUL  = 9'b000000100,
        S_EINT  = 9'b000001000,
        S_EWR   = 9'b000010000,
        S_DRD   = 9'b000100000,
        S_DINIT = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DOUT  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [4:0]         bit_reg, bit_next;
    logic               j_last;

    assign j_last = (CNT_W'(j_reg) == n_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            bit_reg   <= bit_next;
        end
    end

    // sequencer: load, exponentiate each element, divide each element
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        addr       = j_reg;
        case (state_reg)
            S_LOAD:
            begin
                in_ready  = 1'b1;
                addr      = count_reg;
                cmd.first = (count_reg == '0);
                if (in_valid)
                begin
                    cmd.load_we = 1'b1;
                    if (row_end || (CNT_W'(count_reg) == CNT_W'(ROW_LEN - 1)))
                    begin
                        n_next     = CNT_W'(count_reg) + CNT_W'(1);
                        count_next = '0;
                        j_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        count_next = count_reg + IDX_W'(1);
                    end
                end
            end
            S_ERD:
            begin
                cmd.exp_rd = 1'b1;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = S_EINT;
            end
            S_EINT:
            begin
                cmd.exp_int = 1'b1;
                state_next  = S_EWR;
            end
            S_EWR:
            begin
                cmd.exp_wr = 1'b1;
                if (j_last)
                begin
                    j_next     = '0;
                    state_next = S_DRD;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_ERD;
                end
            end
            S_DRD:
            begin
                cmd.div_rd = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                bit_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 5'd1;
                if (bit_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_DOUT;
                end
            end
            S_DOUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = j_last;
                    if (j_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_DRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

### rtl/rsm_dp.sv
module rsm_dp #(
    parameter int ROW_LEN = rsm_pkg::ROW_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rsm_pkg::in_word_t          in_data,
    input  logic                       cfg_we,
    input  logic [15:0]                cfg_data,
    input  rsm_pkg::cmd_t              cmd,
    input  logic [$clog2(ROW_LEN)-1:0] addr,
    output rsm_pkg::sts_t              sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rsm_pkg::out_word_t         out_data
);
    import rsm_pkg::*;

    localparam int SUM_W = $clog2(ROW_LEN * 65536 + 1);
    localparam int DEN_W = SUM_W + 1;

    logic [15:0]        eps_reg;
    logic signed [15:0] max_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [15:0]        logit_rd;
    logic [16:0]        exp_rd;
    logic [16:0]        exp_val;
    logic [24:0]        y_reg;
    logic [16:0]        t0_reg;
    logic [8:0]         k_reg;
    logic [23:0]        frac_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [16:0]        q_reg;
    logic               nbit_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic [15:0]        d;
    logic [32:0]        y_prod;
    logic [3:0]         fi;
    logic [16:0]        t0, t1, tdiff;
    logic [16:0]        m;
    logic [DEN_W-1:0]   denom;
    logic [DEN_W:0]     rem_sh;
    logic               ge;

    // epsilon register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_data;
        end
    end

    rsm_ram #(.WIDTH(16), .DEPTH(ROW_LEN)) u_logit_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (addr),
        .wdata (in_data.logit),
        .raddr (addr),
        .rdata (logit_rd)
    );

    rsm_ram #(.WIDTH(17), .DEPTH(ROW_LEN)) u_exp_ram (
        .clk   (clk),
        .we    (cmd.exp_wr),
        .waddr (addr),
        .wdata (exp_val),
        .raddr (addr),
        .rdata (exp_rd)
    );

    // running max and exponential sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 16'sh8000;
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.load_we && (cmd.first || (in_data.logit > max_reg)))
            begin
                max_reg <= in_data.logit;
            end
            if (cmd.load_we && cmd.first)
            begin
                sum_reg <= '0;
            end
            else if (cmd.exp_wr)
            begin
                sum_reg <= sum_reg + SUM_W'(exp_val);
            end
        end
    end

    // exponent: scale by log2(e), split into shift and table interpolation
    assign d      = 16'(max_reg - $signed(logit_rd));
    assign y_prod = {17'd0, d} * {16'd0, LOG2E_Q16};
    assign fi     = y_reg[15:12];
    assign t0     = pow2_frac({1'b0, fi});
    assign t1     = pow2_frac({1'b0, fi} + 5'd1);
    assign tdiff  = t0 - t1;
    assign m      = t0_reg - 17'(frac_reg[23:12]);
    assign exp_val = (k_reg < 9'd17) ? (m >> k_reg[4:0]) : 17'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.exp_mul)
        begin
            y_reg <= y_prod[32:8];
        end
        if (cmd.exp_int)
        begin
            t0_reg   <= t0;
            k_reg    <= y_reg[24:16];
            frac_reg <= {12'd0, tdiff[11:0]} * {12'd0, y_reg[11:0]};
        end
    end

    // restoring divider, one quotient bit per cycle
    assign denom  = DEN_W'(sum_reg) + DEN_W'(eps_reg);
    assign rem_sh = {rem_reg, nbit_reg};
    assign ge     = (rem_sh >= {1'b0, denom});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= DEN_W'(exp_rd[16:1]);
            nbit_reg <= exp_rd[0];
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? DEN_W'(rem_sh - {1'b0, denom}) : rem_sh[DEN_W-1:0];
            nbit_reg <= 1'b0;
            q_reg    <= {q_reg[15:0], ge};
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.probability  <= q_reg[16] ? 16'hFFFF : q_reg[15:0];
            out_reg.final_of_row <= cmd.out_last;
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

endmodule

### verif/row_softmax_checker.sv
module row_softmax_checker #(
    parameter int ROW_LEN = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  rsm_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  rsm_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    // interpolation points of 2^(-j/16)
    localparam logic [16:0] POW2_TAB [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    logic [15:0]        eps_q;
    logic signed [15:0] row_buf [0:ROW_LEN-1];
    int                 row_fill;
    logic signed [15:0] row_peak;
    out_word_t          prob_q [$];

    assign pending = prob_q.size();

    // exp(-d) in Q1.16 for d in Q8.8
    function automatic logic [16:0] exp_of_gap(input logic [15:0] d);
        logic [47:0] y;
        logic [31:0] k;
        logic [3:0]  i;
        logic [11:0] r;
        logic [31:0] m;
        y = (48'(d) * 48'd94548) >> 8;
        k = 32'(y >> 16);
        i = y[15:12];
        r = y[11:0];
        m = 32'(POW2_TAB[i]) - (((32'(POW2_TAB[i]) - 32'(POW2_TAB[i+1])) * r) >> 12);
        if (k >= 17)
            return 17'd0;
        return 17'(m >> k);
    endfunction

    // close a row: push one probability per element
    task automatic close_row();
        logic [16:0] e [0:ROW_LEN-1];
        logic [31:0] total;
        logic [47:0] q;
        out_word_t   w;
        total = 0;
        for (int j = 0; j < row_fill; j++)
        begin
            e[j] = exp_of_gap(16'(32'(row_peak) - 32'(row_buf[j])));
            total += e[j];
        end
        for (int j = 0; j < row_fill; j++)
        begin
            q = (48'(e[j]) << 16) / 48'(total + eps_q);
            w.probability = (q > 65535) ? 16'hFFFF : q[15:0];
            w.final_of_row = (j == row_fill - 1);
            prob_q.push_back(w);
        end
        row_fill = 0;
    endtask

    // watch config, input and output words
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            eps_q <= EPS_RESET;
            row_fill = 0;
            fail_count <= 0;
            prob_q.delete();
        end
        else
        begin
            if (cfg_we)
                eps_q <= cfg_data;
            if (out_valid && out_ready)
            begin
                if (prob_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected word %h", out_data);
                end
                else
                begin
                    exp_w = prob_q.pop_front();
                    if (exp_w !== out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: prob exp %0d got %0d, last exp %b got %b",
                                     exp_w.probability, out_data.probability,
                                     exp_w.final_of_row, out_data.final_of_row);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (row_fill == 0 || in_data.logit > row_peak)
                    row_peak = in_data.logit;
                row_buf[row_fill] = in_data.logit;
                row_fill++;
                if (in_data.row_end || row_fill == ROW_LEN)
                    close_row();
            end
        end
    end
endmodule

### verif/row_softmax_top_test.sv
module row_softmax_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int ROW_LEN = ROW_LEN_DEF;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    int        fail_count;
    int        pending;
    logic      stall_on = 1'b1;

    row_softmax_top #(.ROW_LEN(ROW_LEN)) u_top (.*);

    row_softmax_checker #(.ROW_LEN(ROW_LEN)) u_chk (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!stall_on)
            out_ready <= 1'b1;
        else
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b0;
                1: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    // send one logit word and wait for acceptance
    task automatic send_logit(input logic signed [15:0] x, input logic last);
        in_valid <= 1'b1;
        in_data.logit <= x;
        in_data.row_end <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle_in(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drain all expected words then write epsilon
    task automatic set_epsilon(input logic [15:0] v);
        idle_in(1);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random row of given length, mostly close logits
    task automatic random_row(input int len);
        logic signed [15:0] base;
        int burst;
        base = 16'($urandom);
        burst = $urandom_range(1, 6);
        for (int j = 0; j < len; j++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_logit(16'($urandom), j == len - 1);
            else
                send_logit(base + 16'($signed($urandom_range(0, 2047)) - 1024),
                           j == len - 1);
            if (--burst == 0)
            begin
                burst = $urandom_range(1, 6);
                if ($urandom_range(0, 1))
                    idle_in($urandom_range(1, 5));
            end
        end
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, single element, full row without end mark
        send_logit(16'sh7FFF, 1'b0);
        send_logit(-16'sh8000, 1'b0);
        send_logit(16'sh0000, 1'b1);
        send_logit(16'sh1234, 1'b1);
        for (int j = 0; j < ROW_LEN; j++)
            send_logit(16'(j * 37), 1'b0);
        set_epsilon(16'd0);
        send_logit(-16'sh8000, 1'b1);
        send_logit(16'sh0100, 1'b0);
        send_logit(16'sh0100, 1'b1);
        set_epsilon(16'hFFFF);
        send_logit(16'sh5555, 1'b0);
        send_logit(-16'sh5556, 1'b1);
        send_logit(16'sh7FFF, 1'b1);
        set_epsilon(16'd1);
        // random rows with epsilon changes
        sent = 10 + ROW_LEN;
        stall_on = 1'b0;
        while (sent < 480)
        begin
            if ($urandom_range(0, 15) == 0)
                set_epsilon(($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 8)));
            if ($urandom_range(0, 20) == 0)
                stall_on = ~stall_on;
            len = ($urandom_range(0, 4) == 0) ? ROW_LEN : $urandom_range(1, ROW_LEN);
            random_row(len);
            sent += len;
        end
        idle_in(1);
        stall_on = 1'b1;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("row_softmax_top_test: PASS");
        else
            $display("row_softmax_top_test: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("row_softmax_top_test: FAIL");
        $finish;
    end
endmodule
